// ===== rtl/core/lrufr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU frame replacer package
// Shared widths, operation codes, sequencer states and the result record.
// ----------------------------------------------------------------------------
package lrufr_pkg;

	localparam int DEF_NUM_FRAMES = 64;
	localparam int OP_W           = 2;
	localparam int FRAME_W        = 6;
	localparam int COUNT_W        = 7;

	localparam logic [OP_W-1:0] OP_VICTIM = 2'd0;
	localparam logic [OP_W-1:0] OP_PIN    = 2'd1;
	localparam logic [OP_W-1:0] OP_UNPIN  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FIN
	} seq_state_t;

	typedef struct packed {
		logic               bad_frame;
		logic [COUNT_W-1:0] evictable_count;
		logic [FRAME_W-1:0] victim_frame;
		logic               victim_valid;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/core/lrufr_order_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Order list memory
// One write port and one registered read port; holds frames oldest first.
// ----------------------------------------------------------------------------
module lrufr_order_mem
	import lrufr_pkg::*;
#(
	parameter int DEPTH  = DEF_NUM_FRAMES,
	parameter int ADDR_W = $clog2(DEF_NUM_FRAMES)
) (
	input  wire logic               clk,
	input  wire logic               we,
	input  wire logic [ADDR_W-1:0]  waddr,
	input  wire logic [FRAME_W-1:0] wdata,
	input  wire logic [ADDR_W-1:0]  raddr,
	output logic      [FRAME_W-1:0] rdata
);

	logic [FRAME_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/core/lrufr_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Replacer sequencer
// Membership flags, entry count and a walk over the order list with one
// shared compare: find the frame to drop, then close the gap behind it.
// ----------------------------------------------------------------------------
module lrufr_seq
	import lrufr_pkg::*;
#(
	parameter int NUM_FRAMES = DEF_NUM_FRAMES
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [OP_W-1:0]    op,
	input  wire logic [FRAME_W-1:0] frame,
	input  wire logic               res_ready,
	output logic                    idle,
	output logic                    done,
	output result_t                 res
);

	localparam int AW     = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int CW     = $clog2(NUM_FRAMES + 1);
	localparam int PRES_N = (NUM_FRAMES < (1 << FRAME_W)) ? NUM_FRAMES : (1 << FRAME_W);
	localparam int PIDX_W = $clog2(PRES_N);

	seq_state_t          state_q, state_d;
	logic [CW-1:0]       cnt_q;
	logic [PRES_N-1:0]   pres_q;
	logic [CW-1:0]       ra_q;
	logic                dv_s1;
	logic [AW-1:0]       pos_s1;
	logic                found_q;
	logic                victim_mode_q;
	logic [FRAME_W-1:0]  frame_q;
	logic                vv_q;
	logic [FRAME_W-1:0]  vf_q;
	logic                bad_q;

	logic                in_range;
	logic                pres_hit;
	logic                is_pin;
	logic                is_unpin;
	logic                is_victim;
	logic                append;
	logic                issue;
	logic                match;
	logic                walk_end;
	logic [PIDX_W-1:0]   clr_idx;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [FRAME_W-1:0]  mem_wdata;
	logic [FRAME_W-1:0]  rd_data;

	assign in_range  = {{(32-FRAME_W){1'b0}}, frame} < 32'(NUM_FRAMES);
	assign pres_hit  = pres_q[frame[PIDX_W-1:0]];
	assign is_victim = (op == OP_VICTIM);
	assign is_pin    = (op == OP_PIN);
	assign is_unpin  = (op == OP_UNPIN);
	assign append    = start && is_unpin && in_range && !pres_hit
	                   && (cnt_q < CW'(NUM_FRAMES));
	assign issue     = (state_q == ST_WALK) && (ra_q != cnt_q);
	assign match     = victim_mode_q || (rd_data == frame_q);
	assign walk_end  = (state_q == ST_WALK) && !issue && !dv_s1;
	assign clr_idx   = victim_mode_q ? vf_q[PIDX_W-1:0] : frame_q[PIDX_W-1:0];

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q[AW-1:0];
		mem_wdata = frame;
		if (append) begin
			mem_we = 1'b1;
		end else if ((state_q == ST_WALK) && dv_s1 && found_q) begin
			mem_we    = 1'b1;
			mem_waddr = pos_s1 - 1'b1;
			mem_wdata = rd_data;
		end
	end

	lrufr_order_mem #(
		.DEPTH  (NUM_FRAMES),
		.ADDR_W (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (ra_q[AW-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		done    = 1'b0;
		idle    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				idle = 1'b1;
				if (start) begin
					if (is_victim && (cnt_q != '0)) begin
						state_d = ST_WALK;
					end else if (is_pin && in_range && pres_hit) begin
						state_d = ST_WALK;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_WALK: begin
				if (walk_end) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (res_ready) begin
					done    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q         <= '0;
			pres_q        <= '0;
			ra_q          <= '0;
			dv_s1         <= 1'b0;
			found_q       <= 1'b0;
			victim_mode_q <= 1'b0;
		end else begin
			dv_s1 <= issue;
			if (start) begin
				ra_q          <= '0;
				found_q       <= 1'b0;
				victim_mode_q <= is_victim;
			end
			if (append) begin
				cnt_q                      <= cnt_q + 1'b1;
				pres_q[frame[PIDX_W-1:0]]  <= 1'b1;
			end
			if (issue) begin
				ra_q <= ra_q + 1'b1;
			end
			if ((state_q == ST_WALK) && dv_s1 && !found_q && match) begin
				found_q <= 1'b1;
			end
			if (walk_end) begin
				cnt_q           <= cnt_q - 1'b1;
				pres_q[clr_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_s1 <= ra_q[AW-1:0];
		if (start) begin
			frame_q <= frame;
			vv_q    <= 1'b0;
			vf_q    <= '0;
			bad_q   <= (is_pin || is_unpin) && !in_range;
		end else if ((state_q == ST_WALK) && dv_s1 && !found_q && victim_mode_q) begin
			vv_q <= 1'b1;
			vf_q <= rd_data;
		end
	end

	assign res.victim_valid    = vv_q;
	assign res.victim_frame    = vf_q;
	assign res.evictable_count = COUNT_W'(cnt_q);
	assign res.bad_frame       = bad_q;

	a_count_matches_flags: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(pres_q) == 32'(cnt_q))
		else $error("flag population differs from entry count");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(NUM_FRAMES))
		else $error("entry count above capacity");

	a_shift_after_found: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && (state_q == ST_WALK)) |-> found_q)
		else $error("order list shifted before the frame was found");

	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (state_q == ST_IDLE))
		else $error("sequencer not idle after result");

endmodule
`default_nettype wire

// ===== rtl/core/lru_frame_replacer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU frame replacer
// Keeps evictable frames in least-recently-unpinned order; serves victim,
// pin and unpin requests and reports the evictable count with each result.
//
// Channel  Dir  Bits                       Content
// s_*      in   tuser[1:0], tdata[5:0]     operation, frame
// m_*      out  tdata[14:0]                victim_valid, victim_frame,
//                                          evictable_count, bad_frame
//
// Unpin, no-op, bad frame, pin of an absent frame, empty victim: no walk.
// Victim and pin of a present frame walk the order list through the
// single memory read port.
// Not ready while a request is in work; the result register frees the
// input side while a result waits on m_tready. No clearing pass at reset.
// ----------------------------------------------------------------------------
module lru_frame_replacer_core
	import lrufr_pkg::*;
#(
	parameter int NUM_FRAMES = DEF_NUM_FRAMES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [5:0] frame, [7:6] zero
	input  wire logic [1:0]  s_tuser,   // [1:0] operation
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata    // [0] victim_valid, [6:1] victim_frame,
	                                    // [13:7] evictable_count, [14] bad_frame
);

	logic    start;
	logic    idle;
	logic    done;
	logic    res_ready;
	result_t res;
	result_t out_q;
	logic    out_vld_q;

	assign s_tready  = idle;
	assign start     = s_tvalid && idle;
	assign res_ready = !out_vld_q || m_tready;

	lrufr_seq #(
		.NUM_FRAMES (NUM_FRAMES)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.op        (s_tuser),
		.frame     (s_tdata[FRAME_W-1:0]),
		.res_ready (res_ready),
		.idle      (idle),
		.done      (done),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (done) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {1'b0, out_q};

endmodule
`default_nettype wire
